>>> hw/rtl/parallax_scroll_wrap_defines.svh
// assertion macros shared by the parallax scroll checker
// no dependencies; included by psw_checker.sv
`ifndef PARALLAX_SCROLL_WRAP_DEFINES_SVH
`define PARALLAX_SCROLL_WRAP_DEFINES_SVH

// same-cycle implication, reset disables
`define PSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disables
`define PSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/psw_pkg.sv
// types and constants for the parallax scroll block
// no dependencies; imported by psw_div, parallax_scroll_wrap and psw_checker
`timescale 1ns / 1ps
`default_nettype none

package psw_pkg;

    typedef logic signed [15:0] coord_t;
    typedef logic [31:0]        word_t;
    typedef logic [2:0]         cfg_idx_t;
    typedef logic [21:0]        wrap_t;
    typedef logic [30:0]        quot_t;

    // register indexes on the config port
    localparam cfg_idx_t CFG_SCALE_X = 3'd0;
    localparam cfg_idx_t CFG_SCALE_Y = 3'd1;
    localparam cfg_idx_t CFG_STEP_X  = 3'd2;
    localparam cfg_idx_t CFG_STEP_Y  = 3'd3;
    localparam cfg_idx_t CFG_SPAN_X  = 3'd4;
    localparam cfg_idx_t CFG_SPAN_Y  = 3'd5;
    localparam cfg_idx_t CFG_MODE    = 3'd6;

    // mode_flags bit positions
    localparam int MODE_AUTO_X = 0;
    localparam int MODE_AUTO_Y = 1;
    localparam int MODE_REV_X  = 2;
    localparam int MODE_REV_Y  = 3;
    localparam int MODE_BIG    = 4;

    // screen size in tiles
    localparam logic [15:0] SCREEN_TILES_X = 16'h0014;
    localparam logic [15:0] SCREEN_TILES_Y = 16'h000F;

    // big-wrap limit, largest positive 32-bit value
    localparam quot_t WRAP_LIMIT = 31'h7FFF_FFFF;

    localparam word_t SCALE_RESET = 32'h0001_0000;

endpackage

`default_nettype wire

>>> hw/rtl/parallax_scroll_wrap.sv
// parallax scroll for one background layer, top level
// depends on psw_pkg and psw_div
//
// channel   direction  handshake              beat
// input     in         in_valid / in_stall    view_x, view_y
// output    out        out_valid / out_stall  scroll_x, scroll_y
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one frame takes the two axes in turn through one multiplier and one divider
// per axis: multiply, offset and finish steps when plain; auto-scroll adds the
// subtract, wrap-high and wrap-low steps, and big wrap with a nonzero span adds
// the divide and wrap-multiply steps; plus an accept step and a hand-off step
// reset clears the accumulators and sets the config registers to defaults
// a stalled result holds in the output register; the next frame still runs
// and waits in its hand-off step, with the input closed, until the output moves
`timescale 1ns / 1ps
`default_nettype none

module parallax_scroll_wrap (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire psw_pkg::coord_t  view_x,
    input  wire psw_pkg::coord_t  view_y,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output psw_pkg::coord_t       scroll_x,
    output psw_pkg::coord_t       scroll_y,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire psw_pkg::cfg_idx_t cfg_index,
    input  wire psw_pkg::word_t   cfg_data
);
    import psw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_OFF,
        S_DIV,
        S_WMUL,
        S_SUB,
        S_WRAPHI,
        S_WRAPLO,
        S_FIN,
        S_OUT
    } state_t;

    // sequencer and datapath registers
    state_t      state_reg, state_next;
    logic        ax_reg, ax_next;          // 0 working on x, 1 on y
    coord_t      cam_x_reg, cam_x_next;
    coord_t      cam_y_reg, cam_y_next;
    word_t       prod_reg, prod_next;
    logic [15:0] off_reg, off_next;
    word_t       a_reg, a_next;
    word_t       w_reg, w_next;
    logic        auto_reg, auto_next;
    coord_t      res_x_reg, res_x_next;
    coord_t      res_y_reg, res_y_next;
    coord_t      scroll_x_reg, scroll_x_next;
    coord_t      scroll_y_reg, scroll_y_next;
    logic        out_valid_reg, out_valid_next;
    word_t       acc_x_reg, acc_x_next;
    word_t       acc_y_reg, acc_y_next;

    // config registers
    word_t       scale_x_reg, scale_x_next;
    word_t       scale_y_reg, scale_y_next;
    logic [15:0] step_x_reg, step_x_next;
    logic [15:0] step_y_reg, step_y_next;
    logic [14:0] span_x_reg, span_x_next;
    logic [14:0] span_y_reg, span_y_next;
    logic [4:0]  mode_reg, mode_next;

    // current-axis views
    coord_t      cur_cam;
    word_t       cur_scale;
    logic [15:0] cur_step;
    logic [14:0] cur_span;
    logic [15:0] cur_screen;
    logic        cur_rev;
    logic        cur_en;
    word_t       cur_acc;
    logic        big;
    wrap_t       span_w;

    // shared multiplier
    word_t       mul_a, mul_b;
    word_t       mul_p;

    // divider hookup
    logic        div_start;
    logic        div_done;
    quot_t       div_q;

    // small helpers
    logic [15:0] span16;
    logic [15:0] span_diff;
    logic [15:0] rev_base;
    logic [15:0] fin_off;
    word_t       acc_wr;

    psw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (span_w),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cur_cam    = ax_reg ? cam_y_reg : cam_x_reg;
    assign cur_scale  = ax_reg ? scale_y_reg : scale_x_reg;
    assign cur_step   = ax_reg ? step_y_reg : step_x_reg;
    assign cur_span   = ax_reg ? span_y_reg : span_x_reg;
    assign cur_screen = ax_reg ? SCREEN_TILES_Y : SCREEN_TILES_X;
    assign cur_rev    = ax_reg ? mode_reg[MODE_REV_Y] : mode_reg[MODE_REV_X];
    assign cur_en     = ax_reg ? mode_reg[MODE_AUTO_Y] : mode_reg[MODE_AUTO_X];
    assign cur_acc    = ax_reg ? acc_y_reg : acc_x_reg;
    assign big        = mode_reg[MODE_BIG];
    assign span_w     = {cur_span, 7'b0};  // span times 128

    // camera times scale in the multiply step, wrap times quotient otherwise;
    // only the low 32 product bits matter in both uses
    assign mul_a    = (state_reg == S_MUL) ? {{16{cur_cam[15]}}, cur_cam}
                                           : {10'b0, span_w};
    assign mul_b    = (state_reg == S_MUL) ? cur_scale : {1'b0, div_q};
    assign mul_p    = mul_a * mul_b;

    // mirror base: (span - screen) * 16, mod 2^16
    assign span16    = {1'b0, cur_span};
    assign span_diff = span16 - cur_screen;
    assign rev_base  = {span_diff[11:0], 4'b0};

    // big wrap adds the accumulator after its update
    assign fin_off = off_reg + ((auto_reg && big) ? cur_acc[18:3] : 16'd0);

    // final wrap-low correction on the stepped accumulator
    assign acc_wr = a_reg[31] ? (a_reg + w_reg) : a_reg;

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        cam_x_next     = cam_x_reg;
        cam_y_next     = cam_y_reg;
        prod_next      = prod_reg;
        off_next       = off_reg;
        a_next         = a_reg;
        w_next         = w_reg;
        auto_next      = auto_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        scroll_x_next  = scroll_x_reg;
        scroll_y_next  = scroll_y_reg;
        out_valid_next = out_valid_reg && out_stall;  // drops once taken
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        div_start      = 1'b0;

        scale_x_next = scale_x_reg;
        scale_y_next = scale_y_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        span_x_next  = span_x_reg;
        span_y_next  = span_y_reg;
        mode_next    = mode_reg;

        // config writes, to be issued only while idle; the block itself does not enforce this
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE_X: scale_x_next = cfg_data;
                CFG_SCALE_Y: scale_y_next = cfg_data;
                CFG_STEP_X:  step_x_next  = cfg_data[15:0];
                CFG_STEP_Y:  step_y_next  = cfg_data[15:0];
                CFG_SPAN_X:  span_x_next  = cfg_data[14:0];
                CFG_SPAN_Y:  span_y_next  = cfg_data[14:0];
                CFG_MODE:    mode_next    = cfg_data[4:0];
                default:     ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cam_x_next = view_x;
                    cam_y_next = view_y;
                    ax_next    = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_OFF;
            end
            S_OFF:
            begin
                off_next  = cur_rev ? (rev_base - prod_reg[31:16]) : prod_reg[31:16];
                auto_next = cur_en && (cur_step != 16'd0);
                if (cur_en && (cur_step != 16'd0))
                begin
                    if (big && (cur_span != 15'd0))
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        w_next     = {10'b0, span_w};
                        state_next = S_SUB;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                // largest multiple of the wrap below 2^31
                w_next     = mul_p;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                a_next = cur_acc - {{16{cur_step[15]}}, cur_step};
                if (!big)
                begin
                    off_next = off_reg + cur_acc[18:3];
                end
                state_next = S_WRAPHI;
            end
            S_WRAPHI:
            begin
                if ($signed(w_reg) < $signed(a_reg))
                begin
                    a_next = a_reg - w_reg;
                end
                state_next = S_WRAPLO;
            end
            S_WRAPLO:
            begin
                if (ax_reg)
                begin
                    acc_y_next = acc_wr;
                end
                else
                begin
                    acc_x_next = acc_wr;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (ax_reg)
                begin
                    res_y_next = 16'd0 - fin_off;
                    state_next = S_OUT;
                end
                else
                begin
                    res_x_next = 16'd0 - fin_off;
                    ax_next    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    scroll_x_next  = res_x_reg;
                    scroll_y_next  = res_y_reg;
                    out_valid_next = 1'b1;
                    ax_next        = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= 1'b0;
            auto_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            scale_x_reg   <= SCALE_RESET;
            scale_y_reg   <= SCALE_RESET;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            mode_reg      <= '0;
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            prod_reg      <= '0;
            off_reg       <= '0;
            a_reg         <= '0;
            w_reg         <= '0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            scroll_x_reg  <= '0;
            scroll_y_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            auto_reg      <= auto_next;
            out_valid_reg <= out_valid_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            scale_x_reg   <= scale_x_next;
            scale_y_reg   <= scale_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            mode_reg      <= mode_next;
            cam_x_reg     <= cam_x_next;
            cam_y_reg     <= cam_y_next;
            prod_reg      <= prod_next;
            off_reg       <= off_next;
            a_reg         <= a_next;
            w_reg         <= w_next;
            res_x_reg     <= res_x_next;
            res_y_reg     <= res_y_next;
            scroll_x_reg  <= scroll_x_next;
            scroll_y_reg  <= scroll_y_next;
        end
    end

    // input side is open only between frames
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign scroll_x  = scroll_x_reg;
    assign scroll_y  = scroll_y_reg;

endmodule

`default_nettype wire

>>> hw/rtl/psw_div.sv
// restoring divider, fixed dividend WRAP_LIMIT, one quotient bit per cycle
// depends on psw_pkg
`timescale 1ns / 1ps
`default_nettype none

module psw_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire psw_pkg::wrap_t divisor,
    output logic               done,
    output psw_pkg::quot_t     quotient
);
    import psw_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    wrap_t       rem_reg, rem_next;
    quot_t       quo_reg, quo_next;
    wrap_t       dvs_reg, dvs_next;
    logic [22:0] shifted;
    logic [22:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[30]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd30;
            rem_next  = '0;
            quo_next  = WRAP_LIMIT;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // borrow clear means the divisor fits
            if (!trial[22])
            begin
                rem_next = trial[21:0];
                quo_next = {quo_reg[29:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[21:0];
                quo_next = {quo_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/psw_checker.sv
// port-level checks for the parallax scroll block, bound to the top level
// depends on psw_pkg and parallax_scroll_wrap_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "parallax_scroll_wrap_defines.svh"

module psw_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire psw_pkg::coord_t   view_x,
    input  wire psw_pkg::coord_t   view_y,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire psw_pkg::coord_t   scroll_x,
    input  wire psw_pkg::coord_t   scroll_y,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire psw_pkg::cfg_idx_t cfg_index,
    input  wire psw_pkg::word_t    cfg_data
);
    import psw_pkg::*;

    logic in_beat;
    logic cfg_seen;

    assign in_beat  = in_valid && !in_stall;
    assign cfg_seen = cfg_valid && (cfg_index == CFG_MODE) && (cfg_data == cfg_data);

    // a result waiting on the output holds its payload
    `PSW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(scroll_x) && $stable(scroll_y), "stalled result changed")

    // an offered input beat waits unchanged while stalled
    `PSW_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(view_x) && $stable(view_y), "stalled input beat changed")

    // a frame keeps the input closed for at least the next cycle
    `PSW_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_beat, in_stall,
        "input open right after a beat")

    // no result can come out in the cycle after a frame enters
    `PSW_ASSERT_NXT(a_no_early_out, clk, rst_n, in_beat, !$rose(out_valid),
        "result too soon after input beat")

    // register writes are never held off
    `PSW_ASSERT_IMP(a_cfg_open, clk, rst_n, cfg_valid || cfg_seen, cfg_ready,
        "config port not ready")

endmodule

bind parallax_scroll_wrap psw_checker u_psw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .view_x    (view_x),
    .view_y    (view_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scroll_x  (scroll_x),
    .scroll_y  (scroll_y),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire
